@@ hw/rtl/mbds_pkg.sv @@
// ----------------------------------------------------------------------------
// mbds_pkg
// Shared types, constants and helper functions of the multibyte delimiter
// splitter.
// ----------------------------------------------------------------------------
package mbds_pkg;

	localparam int DELIM_MAX   = 8;
	localparam int FILL_W      = $clog2(DELIM_MAX + 1);
	localparam int LEN_W       = 4;
	localparam int DBYTES_W    = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = CFG_IDX_W'(1);

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       token_end;
		logic       last;
		logic       done;
	} result_t;

	// Length in use: zero acts as one, anything above the window acts as full.
	function automatic logic [FILL_W-1:0] eff_len(input logic [LEN_W-1:0] n);
		logic [FILL_W-1:0] r;
		if (n == '0)
			r = FILL_W'(1);
		else if (int'(n) > DELIM_MAX)
			r = FILL_W'(DELIM_MAX);
		else
			r = FILL_W'(n);
		return r;
	endfunction

	// Delimiter bytes beyond the packed register compare as zero.
	function automatic logic [7:0] delim_byte(input logic [DBYTES_W-1:0] d, input int k);
		logic [7:0] r;
		r = 8'h00;
		if (k < DBYTES_W / 8)
			r = d[8*k +: 8];
		return r;
	endfunction

endpackage

@@ hw/rtl/mbds_front.sv @@
// ----------------------------------------------------------------------------
// mbds_front
// Input side: accepts bytes and holds them in a short queue so that the
// scanning engine and the input can stall independently.
// ----------------------------------------------------------------------------
module mbds_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic [7:0]      in_byte,
	input  logic            end_of_string,
	output logic            q_valid,
	output mbds_pkg::item_t q_item,
	input  logic            q_pop
);
	import mbds_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign item_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].data <= in_byte;
			mem_q[wr_ptr_q].eos  <= end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count missed a push");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

@@ hw/rtl/mbds_back.sv @@
// ----------------------------------------------------------------------------
// mbds_back
// Scanning engine: keeps the lookahead window, matches the delimiter against
// it; unless stalled, emits up to one result per cycle into an output register.
// ----------------------------------------------------------------------------
module mbds_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  mbds_pkg::item_t               q_item,
	output logic                          q_pop,
	input  logic [mbds_pkg::DBYTES_W-1:0] delim_bytes,
	input  logic [mbds_pkg::LEN_W-1:0]    delim_len,
	output logic                          result_valid,
	input  logic                          result_stall,
	output mbds_pkg::result_t             result
);
	import mbds_pkg::*;

	logic [7:0]        win_q [DELIM_MAX];
	logic [FILL_W-1:0] fill_q;
	logic              tok_q;
	logic              busy_q;
	logic              eos_q;
	logic              res_valid_q;
	result_t           res_q;

	logic [7:0]        w     [DELIM_MAX];
	logic [7:0]        w_nxt [DELIM_MAX];
	logic [FILL_W-1:0] wfill;
	logic [FILL_W-1:0] len;
	logic [FILL_W-1:0] drop;
	logic [FILL_W-1:0] nf;
	logic              weos;
	logic              take;
	logic              act;
	logic              adv;
	logic              go;
	logic              match;
	logic              emit;
	logic              nt;
	logic              more;
	result_t           res_d;

	assign len  = eff_len(delim_len);
	assign adv  = !res_valid_q || !result_stall;
	assign take = !busy_q && q_valid;
	assign act  = busy_q || take;
	assign go   = act && adv;
	assign q_pop = take && adv;

	// A fresh request is written into the window at the fill position before
	// the compare, so an item can finish in the cycle it is taken.
	always_comb begin
		for (int i = 0; i < DELIM_MAX; i++) begin
			if (!busy_q && fill_q == FILL_W'(i))
				w[i] = q_item.data;
			else
				w[i] = win_q[i];
		end
	end

	assign wfill = busy_q ? fill_q : fill_q + FILL_W'(1);
	assign weos  = busy_q ? eos_q : q_item.eos;

	always_comb begin
		match = 1'b1;
		for (int i = 0; i < DELIM_MAX; i++) begin
			if (FILL_W'(i) < len && w[i] != delim_byte(delim_bytes, i))
				match = 1'b0;
		end
	end

	always_comb begin
		emit  = 1'b0;
		drop  = '0;
		nt    = tok_q;
		res_d = '0;
		if (wfill >= len) begin
			emit = 1'b1;
			if (match) begin
				res_d.token_end = 1'b1;
				drop            = len;
				nt              = 1'b0;
			end else begin
				res_d.data = w[0];
				drop       = FILL_W'(1);
				nt         = 1'b1;
			end
		end else if (weos && wfill != '0) begin
			emit       = 1'b1;
			res_d.data = w[0];
			drop       = FILL_W'(1);
			nt         = 1'b1;
		end else if (weos && tok_q) begin
			emit            = 1'b1;
			res_d.token_end = 1'b1;
			nt              = 1'b0;
		end
		nf         = wfill - drop;
		more       = (nf >= len) || (weos && (nf != '0 || nt));
		res_d.last = !more;
		res_d.done = weos && !more;
	end

	always_comb begin
		for (int i = 0; i < DELIM_MAX; i++) begin
			w_nxt[i] = w[i];
			for (int j = 1; j <= DELIM_MAX; j++) begin
				if (drop == FILL_W'(j) && i + j < DELIM_MAX)
					w_nxt[i] = w[i + j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < DELIM_MAX; i++)
				win_q[i] <= w_nxt[i];
			eos_q <= weos;
		end
		if (go && emit)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			tok_q       <= 1'b0;
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (go) begin
				fill_q <= nf;
				tok_q  <= (weos && !more) ? 1'b0 : nt;
				busy_q <= more;
			end
			if (go && emit)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.token_end) |-> (res_q.data == 8'h00))
		else $error("token end with non-zero byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.done) |-> res_q.last)
		else $error("string done without last of run");

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(DELIM_MAX))
		else $error("window fill beyond window");

	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && eos_q && !more && go) |=> (fill_q == '0 && !tok_q))
		else $error("window not cleared at end of string");

endmodule

@@ hw/rtl/multibyte_delimiter_splitter.sv @@
// ----------------------------------------------------------------------------
// multibyte_delimiter_splitter
// Splits a byte stream into tokens at each occurrence of a configured
// delimiter of one to eight bytes.
//
// Bytes enter one per cycle into a four-entry queue; the scanning engine
// behind it takes one queued byte per cycle and produces at most one result
// per cycle, so ordinary bytes sustain one item per clock unless stalled. A
// byte that produces several results (end of string draining the lookahead
// window, or a shortened delimiter rescanning a fuller window) holds the
// engine until all, up to nine, are out, while the queue keeps accepting.
// The limit is the single result register at the output. The delimiter is
// compared against the whole window in parallel. Configuration writes are
// always taken and must only be made while no string byte is in flight.
// ----------------------------------------------------------------------------
module multibyte_delimiter_splitter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           end_of_string,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [7:0]                     out_byte,
	output logic                           is_token_end,
	output logic                           last_of_run,
	output logic                           string_done,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mbds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbds_pkg::DBYTES_W-1:0]  cfg_data
);
	import mbds_pkg::*;

	logic [DBYTES_W-1:0] delim_bytes_q;
	logic [LEN_W-1:0]    delim_len_q;
	logic                q_valid;
	item_t               q_item;
	logic                q_pop;
	result_t             result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q <= '0;
			delim_len_q   <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DELIM_BYTES:  delim_bytes_q <= cfg_data;
				REG_DELIM_LENGTH: delim_len_q   <= cfg_data[LEN_W-1:0];
				default:          ;
			endcase
		end
	end

	mbds_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	mbds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.delim_bytes  (delim_bytes_q),
		.delim_len    (delim_len_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	assign out_byte     = result.data;
	assign is_token_end = result.token_end;
	assign last_of_run  = result.last;
	assign string_done  = result.done;

endmodule

@@ tb/multibyte_delimiter_splitter_tb.sv @@
// ----------------------------------------------------------------------------
// multibyte_delimiter_splitter_tb
// Self-checking bench for the delimiter splitter. Strings are fed as byte
// requests, a behavioural splitter predicts the token bytes and token ends of
// each accepted byte, and every result leaving the block is checked in order.
// Phases change the delimiter and the idling of both sides between strings.
// ----------------------------------------------------------------------------
module multibyte_delimiter_splitter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbds_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 8;
	localparam int SETTLE_CYCLES   = 32;
	localparam int HOLD_CYCLES     = 200;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int ITEMS_PER_PHASE = 24;
	localparam int PHASES          = 5;
	// An index outside the register map; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 item_valid    = 1'b0;
	logic                 item_stall;
	logic [7:0]           in_byte       = 8'h00;
	logic                 end_of_string = 1'b0;
	logic                 result_valid;
	logic                 result_stall  = 1'b0;
	logic [7:0]           out_byte;
	logic                 is_token_end;
	logic                 last_of_run;
	logic                 string_done;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [DBYTES_W-1:0]  cfg_data      = '0;

	// Splitter state as the bench sees it.
	logic [DBYTES_W-1:0]  delim_now     = '0;
	logic [LEN_W-1:0]     delim_len_now = LEN_W'(1);
	logic [7:0]           window [DELIM_MAX];
	int                   window_fill   = 0;
	bit                   token_open    = 1'b0;

	item_t                pending_bytes [$];
	result_t              due_results [$];
	item_t                next_item;
	result_t              want;

	int unsigned          send_idle_pct = 0;
	int unsigned          stall_pct     = 0;
	int                   holds_asked   = 0;
	int                   holds_done    = 0;
	int                   hold_left     = 0;
	int                   error_count   = 0;
	int                   cycle_count   = 0;

	multibyte_delimiter_splitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.is_token_end (is_token_end),
		.last_of_run  (last_of_run),
		.string_done  (string_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Zero acts as one and anything beyond the window acts as a full window.
	function automatic int span_of(input logic [LEN_W-1:0] n);
		if (n == '0)
			return 1;
		if (int'(n) > DELIM_MAX)
			return DELIM_MAX;
		return int'(n);
	endfunction

	function automatic void push_result(input logic [7:0] b, input logic token_end);
		result_t r;
		r.data      = b;
		r.token_end = token_end;
		r.last      = 1'b0;
		r.done      = 1'b0;
		due_results.push_back(r);
	endfunction

	// Works out the results of one accepted byte and appends them in order.
	function automatic void split_byte(input logic [7:0] b, input logic eos);
		int span, first, i, n;
		bit hit;
		result_t r;
		span  = span_of(delim_len_now);
		first = due_results.size();
		if (window_fill < DELIM_MAX) begin
			window[window_fill] = b;
			window_fill++;
		end
		while (window_fill >= span) begin
			hit = 1'b1;
			for (i = 0; i < span; i++)
				if (window[i] != delim_now[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				push_result(8'h00, 1'b1);
				token_open = 1'b0;
				n = span;
			end else begin
				push_result(window[0], 1'b0);
				token_open = 1'b1;
				n = 1;
			end
			for (i = 0; i + n < window_fill; i++)
				window[i] = window[i + n];
			window_fill -= n;
		end
		if (eos) begin
			for (i = 0; i < window_fill; i++) begin
				push_result(window[i], 1'b0);
				token_open = 1'b1;
			end
			if (token_open)
				push_result(8'h00, 1'b1);
			window_fill = 0;
			token_open  = 1'b0;
		end
		if (due_results.size() > first) begin
			r      = due_results.pop_back();
			r.last = 1'b1;
			r.done = eos;
			due_results.push_back(r);
		end
	endfunction

	function automatic void check_field(input string what, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, got_v);
			error_count++;
		end
	endfunction

	function automatic void add_item(input logic [7:0] b, input logic eos);
		item_t it;
		it.data = b;
		it.eos  = eos;
		pending_bytes.push_back(it);
	endfunction

	// Whole strings built mostly from delimiter copies, broken prefixes of the
	// delimiter and its own bytes, with the odd string of plain noise.
	task automatic queue_strings(input int n_items);
		int produced, target, kind, span, k, j;
		bit noise;
		logic [7:0] piece [$];
		produced = 0;
		span = span_of(delim_len_now);
		while (produced < n_items) begin
			target = $urandom_range(1, 12);
			noise  = ($urandom_range(7) == 0);
			piece.delete();
			while (piece.size() < target) begin
				kind = noise ? 9 : $urandom_range(9);
				if (kind <= 3) begin
					for (j = 0; j < span; j++)
						piece.push_back(delim_now[8*j +: 8]);
				end else if (kind <= 5 && span > 1) begin
					k = $urandom_range(1, span - 1);
					for (j = 0; j < k; j++)
						piece.push_back(delim_now[8*j +: 8]);
				end else if (kind <= 7) begin
					piece.push_back(delim_now[8*$urandom_range(span - 1) +: 8]);
				end else begin
					piece.push_back(8'($urandom));
				end
			end
			foreach (piece[j])
				add_item(piece[j], j == piece.size() - 1);
			produced += piece.size();
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DBYTES_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_DELIM_BYTES)
			delim_now = val;
		else if (idx == REG_DELIM_LENGTH)
			delim_len_now = val[LEN_W-1:0];
	endtask

	// A byte that only fills the window gives no result, so a fixed settling
	// pause follows once nothing more is awaited.
	task automatic wait_idle();
		@(posedge clk);
		while (pending_bytes.size() != 0 || item_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Byte requests: a new byte is offered only once the previous one is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid    <= 1'b0;
			in_byte       <= 8'h00;
			end_of_string <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				split_byte(in_byte, end_of_string);
			if (!item_valid || !item_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_bytes.pop_front();
					item_valid    <= 1'b1;
					in_byte       <= next_item.data;
					end_of_string <= next_item.eos;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done != holds_asked) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual data=%h end=%b last=%b done=%b",
					$time, out_byte, is_token_end, last_of_run, string_done);
				error_count++;
			end else begin
				want = due_results.pop_front();
				check_field("out_byte", want.data, out_byte);
				check_field("is_token_end", 8'(want.token_end), 8'(is_token_end));
				check_field("last_of_run", 8'(want.last), 8'(last_of_run));
				check_field("string_done", 8'(want.done), 8'(string_done));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still awaited", $time, due_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int p;
		logic [7:0] a, b;
		logic [DBYTES_W-1:0] d;
		logic [LEN_W-1:0] len;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset delimiter is a single zero byte: leading, repeated and trailing
		// delimiters, so empty tokens and no empty token at the end.
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);
		add_item(8'h00, 1'b0);
		add_item(8'h00, 1'b0);
		add_item(8'h41, 1'b0);
		add_item(8'h00, 1'b1);
		wait_idle();

		// Two-byte delimiter with a broken prefix left in the window at the end.
		write_reg(REG_DELIM_BYTES, 64'h0A0D);
		write_reg(REG_DELIM_LENGTH, 64'd2);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		add_item(8'h0D, 1'b0);
		add_item(8'h0A, 1'b0);
		add_item(8'h61, 1'b0);
		add_item(8'h0D, 1'b0);
		add_item(8'h0A, 1'b0);
		add_item(8'h62, 1'b0);
		add_item(8'h0D, 1'b1);
		wait_idle();

		// Self-overlapping delimiter: matches must not overlap.
		write_reg(REG_DELIM_BYTES, 64'h6161);
		add_item(8'h61, 1'b0);
		add_item(8'h61, 1'b0);
		add_item(8'h61, 1'b1);
		wait_idle();

		// Shorten the delimiter in the middle of a string; the fuller window is
		// rescanned on the next byte.
		write_reg(REG_DELIM_BYTES, 64'h0807060504030201);
		write_reg(REG_DELIM_LENGTH, 64'd8);
		add_item(8'h01, 1'b0);
		add_item(8'h02, 1'b0);
		add_item(8'h03, 1'b0);
		wait_idle();
		write_reg(REG_DELIM_LENGTH, 64'd2);
		add_item(8'h04, 1'b0);
		add_item(8'h05, 1'b1);

		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			a = 8'($urandom);
			b = 8'($urandom);
			for (int j = 0; j < 8; j++)
				d[8*j +: 8] = $urandom_range(1) ? a : b;
			case (p)
				0: len = LEN_W'(1);
				1: begin
					d   = '1;
					len = LEN_W'(8);
				end
				2: begin
					d   = {$urandom, $urandom};
					len = LEN_W'(0);
				end
				3: begin
					d   = '0;
					len = LEN_W'(15);
				end
				default: len = LEN_W'($urandom_range(2, 9));
			endcase
			write_reg(REG_DELIM_BYTES, d);
			write_reg(REG_DELIM_LENGTH, DBYTES_W'(len));
			case (p)
				1: begin
					send_idle_pct <= 68;
					stall_pct     <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					stall_pct     <= 68;
				end
				3: begin
					send_idle_pct <= 24;
					stall_pct     <= 24;
				end
				default: begin
					send_idle_pct <= 0;
					stall_pct     <= 0;
				end
			endcase
			// A long hold-off on the result side while bytes keep coming.
			if (p == 0)
				holds_asked <= holds_asked + 1;
			queue_strings(ITEMS_PER_PHASE);
		end

		wait_idle();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mbds_pkg.sv
hw/rtl/mbds_front.sv
hw/rtl/mbds_back.sv
hw/rtl/multibyte_delimiter_splitter.sv
tb/multibyte_delimiter_splitter_tb.sv
